### hw/rtl/fbba_pkg.sv
// Shared types and constants for the free block bitmap allocator.
package fbba_pkg;

    localparam int BLK_W     = 12;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = 5;
    localparam int CMD_W     = 2;

    localparam logic [BLK_W-1:0] FIRST_DATA_RESET = 12'd12;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Lowest-free search result for one map word
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } find_res_t;

endpackage

### hw/rtl/fbba_if.sv
// Request and response channel interfaces for the allocator.
interface fbba_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbba_pkg::CMD_W-1:0]    cmd;
    logic [fbba_pkg::BLK_W-1:0]    block_number;

    modport source (output valid, output cmd, output block_number, input ready);
    modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

interface fbba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [fbba_pkg::BLK_W-1:0]    result_block;
    logic                          is_free;

    modport source (output valid, output found, output result_block, output is_free,
                    input ready);
    modport sink   (input valid, input found, input result_block, input is_free,
                    output ready);
endinterface

### hw/rtl/free_block_bitmap_allocator.sv
// Top level: first-fit free block bitmap allocator with its command sequencer.
//
// Usage:
//   req channel (valid/ready) carries cmd and block_number; rsp channel carries
//   found, result_block and is_free. Every request gives exactly one response.
//   cmd: allocate, free, check, or no-op (echoes block_number, changes nothing).
//   cfg_we/cfg_wdata set first_data_block, the lowest block allocate may hand
//   out; write it only while no request is in flight.
// Sequencing:
//   One request at a time; req.ready is high only while the sequencer is idle.
//   Free and check: map read, update/compare, response load.
//   No-op and out-of-range block: response load only.
//   Allocate: map read, scan of 1..MAP_WORDS map words (128 for 4096 blocks),
//   response load. The map memory read port and the single lowest-free finder
//   handle one 32-bit word per cycle; the next word's read overlaps the search.
// Reset:
//   rst_n (async, active low) marks every block free (per-word valid bits are
//   cleared, no clearing pass) and sets first_data_block to 12.
// Stalls:
//   The response sits in an output register; a new request is accepted while
//   it waits. A finished result waits in the response state until the output
//   register is free, so nothing is dropped.
module free_block_bitmap_allocator #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    fbba_req_if.sink                     req,
    fbba_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [fbba_pkg::BLK_W-1:0]   cfg_wdata
);

    // Only the first 4096 blocks are addressable with a 12-bit block number.
    localparam int SCAN_LIMIT = (NUM_BLOCKS < (1 << fbba_pkg::BLK_W)) ?
                                NUM_BLOCKS : (1 << fbba_pkg::BLK_W);
    localparam int MAP_WORDS  = (SCAN_LIMIT + fbba_pkg::WORD_BITS - 1) / fbba_pkg::WORD_BITS;
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_WORD  = (SCAN_LIMIT - 1) / fbba_pkg::WORD_BITS;
    localparam int LAST_BIT   = (SCAN_LIMIT - 1) % fbba_pkg::WORD_BITS;
    localparam logic [fbba_pkg::BLK_W:0] LIMIT_V = SCAN_LIMIT[fbba_pkg::BLK_W:0];
    localparam logic [WORD_W-1:0] LAST_W = LAST_WORD[WORD_W-1:0];
    // Bits past the last real block in the final word count as used
    localparam logic [fbba_pkg::WORD_BITS-1:0] HI_MASK =
        ~(32'hFFFF_FFFF >> (fbba_pkg::WORD_BITS - 1 - LAST_BIT));

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [fbba_pkg::BLK_W-1:0]      fdb_reg;
    logic [WORD_W-1:0]               word_reg, word_next;
    logic [fbba_pkg::CMD_W-1:0]      cmd_reg;
    logic [fbba_pkg::BLK_W-1:0]      blk_reg;
    logic                            res_found_reg, res_found_next;
    logic [fbba_pkg::BLK_W-1:0]      res_block_reg, res_block_next;
    logic                            res_free_reg, res_free_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_found_reg;
    logic [fbba_pkg::BLK_W-1:0]      out_block_reg;
    logic                            out_free_reg;

    logic                            accept;
    logic                            req_in_range;
    logic                            fdb_in_range;
    logic                            out_load;
    logic                            rd_en;
    logic [WORD_W-1:0]               rd_addr;
    logic [fbba_pkg::WORD_BITS-1:0]  rd_data;
    logic                            wr_en;
    logic [fbba_pkg::WORD_BITS-1:0]  wr_data;
    logic [fbba_pkg::WORD_BITS-1:0]  scan_mask;
    logic [fbba_pkg::WORD_BITS-1:0]  blk_bit;
    fbba_pkg::find_res_t             find;

    assign req.ready    = (state_reg == ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign req_in_range = ({1'b0, req.block_number} < LIMIT_V);
    assign fdb_in_range = ({1'b0, fdb_reg} < LIMIT_V);
    assign out_load     = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);
    assign blk_bit      = fbba_pkg::WORD_BITS'(1) << blk_reg[fbba_pkg::IDX_W-1:0];

    // Window mask: below first_data_block in its word, past the map end in the last
    always_comb
    begin
        scan_mask = '0;
        if (word_reg == fdb_reg[fbba_pkg::IDX_W +: WORD_W])
        begin
            scan_mask = (fbba_pkg::WORD_BITS'(1) << fdb_reg[fbba_pkg::IDX_W-1:0])
                        - fbba_pkg::WORD_BITS'(1);
        end
        if (word_reg == LAST_W)
        begin
            scan_mask = scan_mask | HI_MASK;
        end
    end

    fbba_find u_find (
        .word (rd_data),
        .mask (scan_mask),
        .res  (find)
    );

    fbba_map #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_W    (WORD_W)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (word_reg),
        .wr_data (wr_data)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        res_found_next = res_found_reg;
        res_block_next = res_block_reg;
        res_free_next  = res_free_reg;
        rd_en          = 1'b0;
        rd_addr        = word_reg + WORD_W'(1);
        wr_en          = 1'b0;
        wr_data        = rd_data | (fbba_pkg::WORD_BITS'(1) << find.idx);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_found_next = 1'b0;
                    res_block_next = req.block_number;
                    res_free_next  = 1'b0;
                    case (req.cmd) inside
                        fbba_pkg::CMD_ALLOC:
                        begin
                            res_block_next = '0;
                            if (fdb_in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = fdb_reg[fbba_pkg::IDX_W +: WORD_W];
                                word_next  = fdb_reg[fbba_pkg::IDX_W +: WORD_W];
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        fbba_pkg::CMD_FREE, fbba_pkg::CMD_CHECK:
                        begin
                            // Out-of-range free answers free, check answers used
                            res_free_next = (req.cmd == fbba_pkg::CMD_FREE);
                            if (req_in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = req.block_number[fbba_pkg::IDX_W +: WORD_W];
                                word_next  = req.block_number[fbba_pkg::IDX_W +: WORD_W];
                                state_next = ST_UPD;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (find.hit)
                begin
                    wr_en          = 1'b1;
                    res_found_next = 1'b1;
                    res_block_next = fbba_pkg::BLK_W'({word_reg, find.idx});
                    state_next     = ST_RESP;
                end
                else if (word_reg == LAST_W)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    // Fetch the next word while this one is searched
                    rd_en     = 1'b1;
                    word_next = word_reg + WORD_W'(1);
                end
            end
            ST_UPD:
            begin
                if (cmd_reg == fbba_pkg::CMD_FREE)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data & ~blk_bit;
                end
                else
                begin
                    res_free_next = ((rd_data & blk_bit) == '0);
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fdb_reg       <= fbba_pkg::FIRST_DATA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fdb_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        res_found_reg <= res_found_next;
        res_block_reg <= res_block_next;
        res_free_reg  <= res_free_next;
        if (accept)
        begin
            cmd_reg <= req.cmd;
            blk_reg <= req.block_number;
        end
        if (out_load)
        begin
            out_found_reg <= res_found_reg;
            out_block_reg <= res_block_reg;
            out_free_reg  <= res_free_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.result_block = out_block_reg;
    assign rsp.is_free      = out_free_reg;

    // An accepted request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a request");

    // The scan never runs past the last map word
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (word_reg <= LAST_W))
        else $error("scan word past end of map");

    // A successful allocation never answers free
    a_found_not_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> !rsp.is_free)
        else $error("allocation result flagged free");

    // Allocated block lies inside the scan window
    a_found_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_found_reg) |->
            ((res_block_reg >= fdb_reg) && ({1'b0, res_block_reg} < LIMIT_V)))
        else $error("allocated block outside scan window");

    // Map writes only happen from the scan or update steps
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_SCAN) || (state_reg == ST_UPD)))
        else $error("map written outside scan/update");

endmodule

### hw/rtl/fbba_map.sv
// Used-block map memory with per-word valid bits (unwritten words read as free).
module fbba_map #(
    parameter int MAP_WORDS = 128,
    parameter int WORD_W    = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [WORD_W-1:0]                  rd_addr,
    output logic [fbba_pkg::WORD_BITS-1:0]     rd_data,
    input  logic                               wr_en,
    input  logic [WORD_W-1:0]                  wr_addr,
    input  logic [fbba_pkg::WORD_BITS-1:0]     wr_data
);

    logic [fbba_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]           valid_reg;
    logic [fbba_pkg::WORD_BITS-1:0] rd_word_reg;
    logic                           rd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

### hw/rtl/fbba_find.sv
// Lowest-zero finder over one map word, with out-of-window bits forced used.
module fbba_find (
    input  logic [fbba_pkg::WORD_BITS-1:0] word,
    input  logic [fbba_pkg::WORD_BITS-1:0] mask,
    output fbba_pkg::find_res_t            res
);

    logic [fbba_pkg::WORD_BITS-1:0] used;

    always_comb
    begin
        used    = word | mask;
        res.hit = ~&used;
        res.idx = '0;
        for (int i = fbba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                res.idx = fbba_pkg::IDX_W'(i);
            end
        end
    end

endmodule
